// ----- rtl/core/ramr_pkg.sv -----
// Package: widths, command codes, controller states and command/status structs.
`default_nettype none
package ramr_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumWidth     = 2 * OperandWidth + 1;
  localparam int unsigned DenWidth     = 2 * OperandWidth;
  localparam int unsigned CntWidth     = 6;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_INC  = 2'd2,
    CMD_PASS = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_FORM,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prod;
    logic form;
    logic gcd_step;
    logic div_start;
    logic div_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_reduce;
    logic gcd_done;
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/ramr_if.sv -----
// Valid/ready channel interfaces for the request and result sides.
`default_nettype none
interface ramr_req_if;
  import ramr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [OperandWidth-1:0]   a_numerator;
  logic [OperandWidth-1:0]   a_denominator;
  logic [OperandWidth-1:0]   b_numerator;
  logic [OperandWidth-1:0]   b_denominator;
  modport source (output valid, command, a_numerator, a_denominator, b_numerator,
                  b_denominator, input ready);
  modport sink (input valid, command, a_numerator, a_denominator, b_numerator,
                b_denominator, output ready);
endinterface

interface ramr_rsp_if;
  import ramr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [NumWidth-1:0]   result_numerator;
  logic [DenWidth-1:0]   result_denominator;
  logic                  inputs_equal;
  modport source (output valid, result_numerator, result_denominator, inputs_equal,
                  input ready);
  modport sink (input valid, result_numerator, result_denominator, inputs_equal,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ramr_ctrl.sv -----
// Controller state machine sequencing load, products, GCD and division.
`default_nettype none
module ramr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  input  wire ramr_pkg::dp_sts_t sts_i,
  output ramr_pkg::dp_cmd_t     cmd_o
);
  import ramr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_FORM;
      end
      ST_FORM: begin
        cmd_o.form = 1'b1;
        state_d    = ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.skip_reduce) begin
          state_d = ST_OUT;
        end else if (sts_i.gcd_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o) else $error("result dropped");
  a_load_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_PROD) else $error("load not followed by products");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/ramr_dp.sv -----
// Datapath: operand registers, products, binary GCD and restoring dividers.
`default_nettype none
module ramr_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ramr_pkg::dp_cmd_t               cmd_i,
  output ramr_pkg::dp_sts_t                    sts_o,
  input  wire logic [1:0]                      command_i,
  input  wire logic [ramr_pkg::OperandWidth-1:0] an_i,
  input  wire logic [ramr_pkg::OperandWidth-1:0] ad_i,
  input  wire logic [ramr_pkg::OperandWidth-1:0] bn_i,
  input  wire logic [ramr_pkg::OperandWidth-1:0] bd_i,
  output logic [ramr_pkg::NumWidth-1:0]        num_o,
  output logic [ramr_pkg::DenWidth-1:0]        den_o,
  output logic                                 eq_o
);
  import ramr_pkg::*;
  localparam int unsigned W = OperandWidth;

  logic [1:0]          op_q;
  logic [W-1:0]        an_q, ad_q, bn_q, bd_q;
  logic                eq_q;
  logic [DenWidth-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [NumWidth-1:0] num_q, den_q;     // raw fraction (den held wide)
  logic [NumWidth-1:0] gx_q, gy_q;       // binary GCD operands
  logic [CntWidth-1:0] sh_q;             // common power of two
  logic [NumWidth-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CntWidth-1:0] cnt_q;
  logic                ddone_q;
  logic [NumWidth-1:0] g;
  logic [NumWidth:0]   tn, td;

  // the operand left nonzero holds the odd part of the gcd
  assign g = (gx_q | gy_q) << sh_q;
  assign tn = {rn_q, qn_q[NumWidth-1]};
  assign td = {rd_q, qd_q[NumWidth-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ddone_q <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.div_start) begin
      ddone_q <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q   <= cnt_q + 1'b1;
      ddone_q <= (cnt_q == CntWidth'(NumWidth - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    // capture request
    if (cmd_i.load) begin
      op_q <= command_i;
      an_q <= an_i; ad_q <= ad_i; bn_q <= bn_i; bd_q <= bd_i;
      eq_q <= (an_i == bn_i) && (ad_i == bd_i);
    end
    // one multiplier row per product, registered
    if (cmd_i.prod) begin
      p1_q <= DenWidth'(an_q) * DenWidth'(bd_q);
      p2_q <= DenWidth'(ad_q) * DenWidth'(bn_q);
      p3_q <= DenWidth'(ad_q) * DenWidth'(bd_q);
      p4_q <= DenWidth'(an_q) * DenWidth'(bn_q);
    end
    if (cmd_i.form) begin
      case (cmd_e'(op_q))
        CMD_ADD: begin
          num_q <= NumWidth'(p1_q) + NumWidth'(p2_q);
          den_q <= NumWidth'(p3_q);
        end
        CMD_MUL: begin
          num_q <= NumWidth'(p4_q);
          den_q <= NumWidth'(p3_q);
        end
        CMD_INC: begin
          num_q <= NumWidth'(an_q) + NumWidth'(ad_q);
          den_q <= NumWidth'(ad_q);
        end
        default: begin
          num_q <= NumWidth'(an_q);
          den_q <= NumWidth'(ad_q);
        end
      endcase
      gx_q <= '0; gy_q <= '0; sh_q <= '0;
    end
    // binary GCD, one step per cycle
    if (cmd_i.gcd_step) begin
      if (gx_q == '0 && gy_q == '0) begin
        gx_q <= num_q; gy_q <= den_q;
      end else if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + 1'b1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q >= gy_q) begin
        gx_q <= (gx_q - gy_q) >> 1;
      end else begin
        gy_q <= (gy_q - gx_q) >> 1;
      end
    end
    // two restoring dividers by the gcd, one bit per cycle
    if (cmd_i.div_start) begin
      qn_q <= num_q; qd_q <= den_q; rn_q <= '0; rd_q <= '0;
    end else if (cmd_i.div_step) begin
      if (tn >= {1'b0, g}) begin
        rn_q <= NumWidth'(tn - {1'b0, g}); qn_q <= {qn_q[NumWidth-2:0], 1'b1};
      end else begin
        rn_q <= tn[NumWidth-1:0]; qn_q <= {qn_q[NumWidth-2:0], 1'b0};
      end
      if (td >= {1'b0, g}) begin
        rd_q <= NumWidth'(td - {1'b0, g}); qd_q <= {qd_q[NumWidth-2:0], 1'b1};
      end else begin
        rd_q <= td[NumWidth-1:0]; qd_q <= {qd_q[NumWidth-2:0], 1'b0};
      end
    end
  end

  // gcd is done when one operand reaches zero after loading
  assign sts_o.skip_reduce = (num_q == '0) || (den_q == '0);
  assign sts_o.gcd_done    = (gx_q != '0 || gy_q != '0) && (gx_q == '0 || gy_q == '0)
                             && !cmd_i.form;
  assign sts_o.div_done    = ddone_q;

  assign num_o = sts_o.skip_reduce ? num_q : qn_q;
  assign den_o = sts_o.skip_reduce ? DenWidth'(den_q) : DenWidth'(qd_q);
  assign eq_o  = eq_q;

`ifndef SYNTHESIS
  a_gx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (gx_q != '0) || (gy_q != '0)) else $error("zero gcd");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q < CntWidth'(NumWidth)) else $error("divider overrun");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> !ddone_q) else $error("done too early");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/rational_add_multiply_reduce_top.sv -----
// Top level: rational add/multiply/increment with reduction to lowest terms.
//  channel  dir  fields
//  req      in   command, a_numerator, a_denominator, b_numerator, b_denominator
//  rsp      out  result_numerator, result_denominator, inputs_equal
// One request at a time: load, products, fraction, binary GCD steps (their number
// set by operand bit lengths), divider steps, then the result is held.
// Reset is asynchronous, active low; it returns the controller to idle.
// A stalled result holds the block; the next request is taken after it leaves.
`default_nettype none
module rational_add_multiply_reduce_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ramr_req_if.sink  req,
  ramr_rsp_if.source rsp
);
  import ramr_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t dsts;

  ramr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid), .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid), .rsp_ready_i (rsp.ready),
    .sts_i (dsts), .cmd_o (dcmd)
  );

  ramr_dp u_dp (
    .clk_i, .rst_ni, .cmd_i (dcmd), .sts_o (dsts),
    .command_i (req.command), .an_i (req.a_numerator), .ad_i (req.a_denominator),
    .bn_i (req.b_numerator), .bd_i (req.b_denominator),
    .num_o (rsp.result_numerator), .den_o (rsp.result_denominator),
    .eq_o (rsp.inputs_equal)
  );
endmodule
`default_nettype wire
